[src/linear_regression_slope_assert.svh]
// Assertion macros used by the checker file of the slope block.
`ifndef LINEAR_REGRESSION_SLOPE_ASSERT_SVH
`define LINEAR_REGRESSION_SLOPE_ASSERT_SVH

// Check the consequent in the cycle after the antecedent.
`define LRS_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error("slope block assertion failed");

// Check the consequent in the same cycle as the antecedent.
`define LRS_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error("slope block assertion failed");

`endif

[src/lrs_pkg.sv]
// Shared widths, constants, codes and command/status types of the slope block.
`timescale 1ns / 1ps
package lrs_pkg;
    localparam int XW          = 16;
    localparam int CNT_W       = 16;
    localparam int SX_W        = 32;
    localparam int SXY_W       = 48;
    localparam int ACC_W       = 52;
    localparam int PA_W        = 33;
    localparam int PB_W        = 17;
    localparam int P_W         = PA_W + PB_W;
    localparam int DVD_W       = 64;
    localparam int DVS_W       = 48;
    localparam int Q_W         = 48;
    localparam int IT_W        = 7;
    localparam int SLOPE_W     = 48;
    localparam int FRAC_W      = 16;
    localparam int MAX_SAMPLES_DEF = 65535;
    localparam int MEAN_ITERS  = 33;
    localparam int SLOPE_ITERS = 64;

    localparam logic [SLOPE_W-1:0] SLOPE_MAXP = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_MAXN = {1'b1, {(SLOPE_W-1){1'b0}}};

    // Steps of the centering pass, one multiply each.
    typedef enum logic [2:0] {
        MOP_MYSX = 3'd0,
        MOP_MXSY = 3'd1,
        MOP_MXMY = 3'd2,
        MOP_NMM1 = 3'd3,
        MOP_MXSX = 3'd4,
        MOP_MXMX = 3'd5,
        MOP_NMM2 = 3'd6
    } t_mop;

    typedef enum logic [1:0] {
        DS_MX    = 2'd0,
        DS_MY    = 2'd1,
        DS_SLOPE = 2'd2
    } t_dsel;

    typedef struct packed {
        logic  acc_en;
        logic  clr;
        logic  div_start;
        t_dsel div_sel;
        logic  mx_ld;
        logic  my_ld;
        logic  mop_en;
        t_mop  mop;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic den_zero;
    } t_sts;
endpackage

[src/linear_regression_slope.sv]
// Top level of the least-squares slope block.
`timescale 1ns / 1ps
// Takes one signed (x, y) pair per cycle while collecting a set and keeps the
// count and the sums of x, y, x*y and x*x; pairs beyond MAX_SAMPLES are dropped.
// The pair flagged tlast closes the set: the block then stops taking pairs
// while it works out the result (a setup step, two mean divisions, 7 centering
// multiplies, the settle states, a slope division that is skipped when all x are
// equal, and a load step, all on one shared radix-2 divider and one 33x17
// multiplier) and emits one word with the truncated means, the Q31.16 slope and
// the zero-spread and saturation flags. A finished word waits in the output
// register while the next set is collected; intake stays closed longer only if
// the following result is ready before that word is taken.
module linear_regression_slope import lrs_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_value[15:0], y_value[31:16]
    input  logic        s_axis_tlast,   // last_sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // mean_x[15:0], mean_y[31:16], slope[79:32]
    output logic [1:0]  m_axis_tuser    // zero_spread[0], saturated[1]
);
    t_cmd                      w_cmd;
    t_sts                      w_sts;
    logic signed [XW-1:0]      w_mean_x, w_mean_y;
    logic signed [SLOPE_W-1:0] w_slope;
    logic                      w_zero, w_sat;

    lrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    lrs_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_x      (s_axis_tdata[15:0]),
        .i_y      (s_axis_tdata[31:16]),
        .o_mean_x (w_mean_x),
        .o_mean_y (w_mean_y),
        .o_slope  (w_slope),
        .o_zero   (w_zero),
        .o_sat    (w_sat)
    );

    assign m_axis_tdata = {w_slope, w_mean_y, w_mean_x};
    assign m_axis_tuser = {w_sat, w_zero};
endmodule

[src/lrs_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module lrs_div import lrs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [IT_W-1:0]  i_iters,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [Q_W-1:0]   r_q;
    logic [IT_W-1:0]  r_cnt;
    logic             r_done;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= i_iters;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == IT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_q   <= {r_q[Q_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

[src/lrs_datapath.sv]
// Sums, means, centering multiplies and slope formatting of the slope block.
`timescale 1ns / 1ps
module lrs_datapath import lrs_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic signed [XW-1:0]      i_x,
    input  logic signed [XW-1:0]      i_y,
    output logic signed [XW-1:0]      o_mean_x,
    output logic signed [XW-1:0]      o_mean_y,
    output logic signed [SLOPE_W-1:0] o_slope,
    output logic                      o_zero,
    output logic                      o_sat
);
    logic [CNT_W-1:0]          r_cnt;
    logic signed [SX_W-1:0]    r_sx, r_sy;
    logic signed [SXY_W-1:0]   r_sxy, r_sxx;
    logic signed [XW-1:0]      r_mx, r_my;
    logic signed [P_W-1:0]     r_p;
    t_mop                      r_pstep;
    logic                      r_pvalid;
    logic signed [ACC_W-1:0]   r_num, r_den;
    logic signed [XW-1:0]      r_omx, r_omy;
    logic signed [SLOPE_W-1:0] r_oslope;
    logic                      r_ozero, r_osat;

    logic                      w_room;
    logic signed [2*XW-1:0]    w_xy, w_xx;
    logic signed [PA_W-1:0]    w_a;
    logic signed [PB_W-1:0]    w_b;
    logic signed [P_W-1:0]     w_prod;
    logic signed [PB_W-1:0]    w_n;
    logic [PA_W-1:0]           w_abs_sx, w_abs_sy;
    logic [DVD_W-1:0]          w_dvd;
    logic [DVS_W-1:0]          w_dvs;
    logic [IT_W-1:0]           w_iters;
    logic                      w_done;
    logic [Q_W-1:0]            w_quot;
    logic                      w_neg;
    logic [ACC_W-1:0]          w_mag_full;
    logic [Q_W-1:0]            w_mag;
    logic                      w_ovf;
    logic [SLOPE_W-1:0]        w_smag;
    logic                      w_sat;
    logic [SLOPE_W-1:0]        w_slope;

    assign w_room = r_cnt < CNT_W'(MAX_SAMPLES);
    assign w_xy   = i_x * i_y;
    assign w_xx   = i_x * i_x;
    assign w_n    = signed'({1'b0, r_cnt});

    // Sample accumulation; clear after each result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxy <= '0;
            r_sxx <= '0;
        end else if (i_cmd.acc_en && w_room) begin
            r_cnt <= r_cnt + 1'b1;
            r_sx  <= r_sx + SX_W'(i_x);
            r_sy  <= r_sy + SX_W'(i_y);
            r_sxy <= r_sxy + SXY_W'(w_xy);
            r_sxx <= r_sxx + SXY_W'(w_xx);
        end
    end

    // Operand select of the shared multiplier.
    always_comb begin
        unique case (i_cmd.mop)
            MOP_MYSX: begin w_a = PA_W'(r_sx);         w_b = PB_W'(r_my); end
            MOP_MXSY: begin w_a = PA_W'(r_sy);         w_b = PB_W'(r_mx); end
            MOP_MXMY: begin w_a = PA_W'(r_mx);         w_b = PB_W'(r_my); end
            MOP_NMM1: begin w_a = signed'(r_p[PA_W-1:0]); w_b = w_n;      end
            MOP_MXSX: begin w_a = PA_W'(r_sx);         w_b = PB_W'(r_mx); end
            MOP_MXMX: begin w_a = PA_W'(r_mx);         w_b = PB_W'(r_mx); end
            MOP_NMM2: begin w_a = signed'(r_p[PA_W-1:0]); w_b = w_n;      end
            default:  begin w_a = '0;                  w_b = '0;          end
        endcase
    end

    assign w_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvalid <= 1'b0;
        end else begin
            r_pvalid <= i_cmd.mop_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mop_en) begin
            r_p     <= w_prod;
            r_pstep <= i_cmd.mop;
        end
        // Fold last cycle's product into the centered sums.
        if (r_pvalid) begin
            unique case (r_pstep)
                MOP_MYSX: r_num <= ACC_W'(r_sxy) - ACC_W'(r_p);
                MOP_MXSY: r_num <= r_num - ACC_W'(r_p);
                MOP_NMM1: r_num <= r_num + ACC_W'(r_p);
                MOP_MXSX: r_den <= ACC_W'(r_sxx) - (ACC_W'(r_p) <<< 1);
                MOP_NMM2: r_den <= r_den + ACC_W'(r_p);
                MOP_MXMY, MOP_MXMX: ;
                default: ;
            endcase
        end
    end

    // Divider operands.
    assign w_abs_sx = r_sx[SX_W-1] ? PA_W'(-PA_W'(r_sx)) : PA_W'(r_sx);
    assign w_abs_sy = r_sy[SX_W-1] ? PA_W'(-PA_W'(r_sy)) : PA_W'(r_sy);

    assign w_neg      = r_num[ACC_W-1];
    assign w_mag_full = w_neg ? ACC_W'(-r_num) : ACC_W'(r_num);
    assign w_mag      = w_mag_full[Q_W-1:0];

    always_comb begin
        unique case (i_cmd.div_sel)
            DS_MX: begin
                w_dvd   = {w_abs_sx, {(DVD_W-PA_W){1'b0}}};
                w_dvs   = DVS_W'(r_cnt);
                w_iters = IT_W'(MEAN_ITERS);
            end
            DS_MY: begin
                w_dvd   = {w_abs_sy, {(DVD_W-PA_W){1'b0}}};
                w_dvs   = DVS_W'(r_cnt);
                w_iters = IT_W'(MEAN_ITERS);
            end
            DS_SLOPE: begin
                w_dvd   = {w_mag, {FRAC_W{1'b0}}};
                w_dvs   = r_den[DVS_W-1:0];
                w_iters = IT_W'(SLOPE_ITERS);
            end
            default: begin
                w_dvd   = '0;
                w_dvs   = '0;
                w_iters = '0;
            end
        endcase
    end

    lrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .i_iters    (w_iters),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.mx_ld) begin
            r_mx <= r_sx[SX_W-1] ? XW'(-w_quot[XW-1:0]) : w_quot[XW-1:0];
        end
        if (i_cmd.my_ld) begin
            r_my <= r_sy[SX_W-1] ? XW'(-w_quot[XW-1:0]) : w_quot[XW-1:0];
        end
    end

    // Quotient reaches 2^48 exactly when mag >= den * 2^32.
    assign w_ovf = (r_den[DVS_W-1:FRAC_W] == '0) &&
                   (w_mag >= {r_den[FRAC_W-1:0], 32'b0});

    always_comb begin
        w_sat  = 1'b0;
        w_smag = w_quot;
        priority if (w_ovf) begin
            w_sat  = 1'b1;
            w_smag = w_neg ? SLOPE_MAXN : SLOPE_MAXP;
        end else if (!w_neg && w_quot > SLOPE_MAXP) begin
            w_sat  = 1'b1;
            w_smag = SLOPE_MAXP;
        end else if (w_neg && w_quot > SLOPE_MAXN) begin
            w_sat  = 1'b1;
            w_smag = SLOPE_MAXN;
        end else begin
            w_smag = w_quot;
        end
        w_slope = w_neg ? SLOPE_W'(-w_smag) : w_smag;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_omx <= r_mx;
            r_omy <= r_my;
            if (r_den == '0) begin
                r_oslope <= '0;
                r_ozero  <= 1'b1;
                r_osat   <= 1'b0;
            end else begin
                r_oslope <= w_slope;
                r_ozero  <= 1'b0;
                r_osat   <= w_sat;
            end
        end
    end

    assign o_sts.div_done = w_done;
    assign o_sts.den_zero = (r_den == '0);
    assign o_mean_x = r_omx;
    assign o_mean_y = r_omy;
    assign o_slope  = r_oslope;
    assign o_zero   = r_ozero;
    assign o_sat    = r_osat;
endmodule

[src/lrs_ctrl.sv]
// Sequencer of the slope block: accumulate, means, centering, divide, deliver.
`timescale 1ns / 1ps
module lrs_ctrl import lrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_last,
    output logic o_in_ready,
    input  logic i_out_ready,
    output logic o_out_valid,
    output t_cmd o_cmd,
    input  t_sts i_sts
);
    typedef enum logic [3:0] {
        S_ACC, S_STX, S_DIVX, S_DIVY, S_MUL, S_CHK, S_DEN, S_DIVS, S_OUT
    } t_state;

    t_state r_state, n_state;
    t_mop   r_mop, n_mop;
    logic   r_ovalid, n_ovalid;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        n_mop   = r_mop;
        w_cmd   = '0;
        w_cmd.mop     = r_mop;
        w_cmd.div_sel = DS_MX;
        unique case (r_state)
            S_ACC: begin
                if (i_in_valid) begin
                    w_cmd.acc_en = 1'b1;
                    if (i_in_last) begin
                        n_state = S_STX;
                    end
                end
            end
            // Start the mean division once the last word is in the sums.
            S_STX: begin
                w_cmd.div_start = 1'b1;
                n_state         = S_DIVX;
            end
            S_DIVX: begin
                if (i_sts.div_done) begin
                    w_cmd.mx_ld     = 1'b1;
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DS_MY;
                    n_state         = S_DIVY;
                end
            end
            S_DIVY: begin
                if (i_sts.div_done) begin
                    w_cmd.my_ld = 1'b1;
                    n_mop       = MOP_MYSX;
                    n_state     = S_MUL;
                end
            end
            S_MUL: begin
                w_cmd.mop_en = 1'b1;
                if (r_mop == MOP_NMM2) begin
                    n_state = S_CHK;
                end else begin
                    n_mop = t_mop'(r_mop + 3'd1);
                end
            end
            // Let the last product settle into the denominator.
            S_CHK: n_state = S_DEN;
            S_DEN: begin
                if (i_sts.den_zero) begin
                    n_state = S_OUT;
                end else begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_sel   = DS_SLOPE;
                    n_state         = S_DIVS;
                end
            end
            S_DIVS: begin
                w_cmd.div_sel = DS_SLOPE;
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                w_cmd.div_sel = DS_SLOPE;
                if (!r_ovalid || i_out_ready) begin
                    w_cmd.out_ld = 1'b1;
                    w_cmd.clr    = 1'b1;
                    n_state      = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
        n_ovalid = w_cmd.out_ld || (r_ovalid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_mop    <= MOP_MYSX;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mop    <= n_mop;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = w_cmd;
endmodule

[src/lrs_checker.sv]
// Port-level checks of the slope block and their binding to the top level.
`timescale 1ns / 1ps
`include "linear_regression_slope_assert.svh"
module lrs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // Hold a stalled result word.
    `LRS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    // Closing a set stops intake while the result is worked out.
    `LRS_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
    // Zero spread gives a zero, unclipped slope.
    `LRS_ASSERT_NOW(a_zero_slope, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[79:32] == 48'd0) && !m_axis_tuser[1])
    // A clipped slope sits at one end of the range.
    `LRS_ASSERT_NOW(a_sat_limit, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata[79:32] == 48'h7FFF_FFFF_FFFF) || (m_axis_tdata[79:32] == 48'h8000_0000_0000))
endmodule

bind linear_regression_slope lrs_checker u_lrs_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the least-squares slope block.
`timescale 1ns / 1ps
module testbench;
    import lrs_pkg::*;

    typedef struct {
        logic signed [15:0] mean_x;
        logic signed [15:0] mean_y;
        logic [47:0]        slope;
        logic               zero_spread;
        logic               saturated;
    } fit_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
        logic               known;
        fit_t               fit;
    } pair_row_t;

    localparam int N_SAMPLES_CAP = 65535;
    localparam int QUIET_LIMIT   = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // x_value[15:0], y_value[31:16]
    logic        s_axis_tlast;   // last_sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // mean_x[15:0], mean_y[31:16], slope[79:32]
    logic [1:0]  m_axis_tuser;   // zero_spread[0], saturated[1]

    linear_regression_slope dut (.*);

    // predictor state
    int          n_pairs;
    longint      acc_x, acc_y, acc_xy, acc_xx;
    fit_t        fits_due[$];

    int idle_pct;
    int stall_pct;
    int hold_cnt;
    int errors;
    int mismatches;
    int fits_seen;
    int quiet;
    int words_sent;
    int zero_seen;

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic fit_t add_pair(logic signed [15:0] x, logic signed [15:0] y,
                                      logic last);
        fit_t   f;
        longint n, mx, my, num, den;
        logic [63:0] mag, q, r, cap;
        logic   neg;
        f = '{default: '0};
        if (n_pairs < N_SAMPLES_CAP) begin
            n_pairs++;
            acc_x  += x;
            acc_y  += y;
            acc_xy += longint'(x) * longint'(y);
            acc_xx += longint'(x) * longint'(x);
        end
        if (!last) return f;
        n   = (n_pairs == 0) ? 1 : n_pairs;
        mx  = acc_x / n;
        my  = acc_y / n;
        num = acc_xy - my * acc_x - mx * acc_y + n * mx * my;
        den = acc_xx - 2 * mx * acc_x + n * mx * mx;
        f.mean_x = mx[15:0];
        f.mean_y = my[15:0];
        if (den <= 0) begin
            f.zero_spread = 1'b1;
        end else begin
            neg = num < 0;
            mag = neg ? -num : num;
            q   = mag / den;
            r   = mag % den;
            cap = neg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
            if (q >= 64'h1_0000_0000) begin
                f.saturated = 1'b1;
                mag = cap;
            end else begin
                mag = (q << 16) + (r << 16) / den;
                if (mag > cap) begin
                    f.saturated = 1'b1;
                    mag = cap;
                end
            end
            f.slope = neg ? 48'(-mag) : mag[47:0];
        end
        n_pairs = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        acc_xx = 0;
        return f;
    endfunction

    // Offer one word, wait for the handshake, then log its expected fit.
    task automatic send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
        fit_t f;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {y, x};
        s_axis_tlast  = last;
        do @(posedge i_clk); while (!s_axis_tready);
        f = add_pair(x, y, last);
        if (last) fits_due.push_back(f);
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (fits_due.size() != 0) @(negedge i_clk);
    endtask

    // Random set: lengths mostly short, content of several shapes.
    task automatic send_set();
        int len, shape, k;
        logic signed [15:0] x, y, x0;
        len   = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(12, 1);
        shape = $urandom_range(4);
        x0    = $urandom;
        for (k = 0; k < len; k++) begin
            case (shape)
                0: begin x = $urandom; y = $urandom; end
                1: begin x = $urandom_range(8) - 4; y = $urandom_range(200) - 100; end
                2: begin x = x0; y = $urandom; end
                3: begin x = $urandom_range(1); y = $urandom; end
                default: begin
                    x = $urandom_range(2000) - 1000;
                    y = 3 * x + $urandom_range(20) - 10;
                end
            endcase
            send_pair(x, y, k == len - 1);
        end
    endtask

    pair_row_t rows[$];

    task automatic add_row(int x, int y, bit last, bit known = 0,
                           int mx = 0, int my = 0, longint slope = 0, bit zs = 0);
        pair_row_t r;
        r.x = x;
        r.y = y;
        r.last = last;
        r.known = known;
        r.fit = '{mean_x: mx, mean_y: my, slope: slope, zero_spread: zs, saturated: 0};
        rows.push_back(r);
    endtask

    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            m_axis_tready = 1'b0;
            hold_cnt--;
        end else begin
            m_axis_tready = $urandom_range(99) >= stall_pct;
        end
    end

    always @(posedge i_clk) begin
        fit_t exp_f, got;
        if (i_rst_n) begin
            quiet++;
            if (s_axis_tvalid && s_axis_tready) quiet = 0;
            if (m_axis_tvalid && m_axis_tready) begin
                quiet = 0;
                got.mean_x      = m_axis_tdata[15:0];
                got.mean_y      = m_axis_tdata[31:16];
                got.slope       = m_axis_tdata[79:32];
                got.zero_spread = m_axis_tuser[0];
                got.saturated   = m_axis_tuser[1];
                fits_seen++;
                if (fits_due.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10) $display("unexpected result word %p", got);
                end else begin
                    exp_f = fits_due.pop_front();
                    if (got.zero_spread) zero_seen++;
                    if (got !== exp_f) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("result %0d: expected %p, got %p", fits_seen, exp_f, got);
                    end
                end
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("no handshake for %0d cycles, %0d results pending",
                         quiet, fits_due.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int i, ph;
        pair_row_t r;
        fit_t f;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        idle_pct = 0;
        stall_pct = 0;
        hold_cnt = 0;
        errors = 0;
        mismatches = 0;
        fits_seen = 0;
        quiet = 0;
        words_sent = 0;
        zero_seen = 0;
        n_pairs = 0;
        acc_x = 0;
        acc_y = 0;
        acc_xy = 0;
        acc_xx = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: single-pair sets, unit slopes, negative means
        add_row(32767, -32768, 1, 1, 32767, -32768, 0, 1);
        add_row(-32768, 32767, 1, 1, -32768, 32767, 0, 1);
        add_row(0, 0, 0);
        add_row(1, 1, 1, 1, 0, 0, 65536, 0);
        add_row(-32768, -32768, 0);
        add_row(32767, 32767, 1, 1, 0, 0, 65536, 0);
        add_row(-1, 0, 0);
        add_row(-2, 0, 1, 1, -1, 0, 0, 0);
        add_row(-32768, 32767, 0);
        add_row(32767, -32768, 1);
        add_row(5, 100, 0);
        add_row(5, -7, 0);
        add_row(5, 3, 1);
        add_row(-3, -32768, 0);
        add_row(0, 0, 0);
        add_row(3, 32767, 1);
        foreach (rows[i]) begin
            r = rows[i];
            send_pair(r.x, r.y, r.last);
            if (r.last && r.known) begin
                f = fits_due[$];
                if (f !== r.fit) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("row %0d: predictor gives %p, table %p", i, f, r.fit);
                end
            end
        end
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 77; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 77; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            // long receiver hold-off while sets keep coming in
            if (ph == 4) hold_cnt = 1500;
            while (words_sent < 80 + 150 * (ph + 1)) send_set();
            drain();
        end
        repeat (200) @(negedge i_clk);

        $display("%0d words in, %0d results checked (%0d zero-spread), %0d errors",
                 words_sent, fits_seen, zero_seen, errors);
        $display("covered full-scale, short, long and constant-x sets under stalls");
        if (errors == 0 && fits_due.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
